// ===== design/moc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package moc_pkg;

  localparam int unsigned PANEL_WIDTH  = 128;
  localparam int unsigned PANEL_HEIGHT = 64;
  localparam int unsigned PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int unsigned MEM_SIZE     = PANEL_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W       = $clog2(MEM_SIZE);

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COL_W        = 7;
  localparam int unsigned ROW_W        = 6;
  localparam int unsigned OP_W         = 2;

  localparam logic [BYTE_W-1:0] CONTRAST_RESET = 8'd127;

  typedef enum logic [OP_W-1:0] {
    OP_CMD  = 2'd0,
    OP_DATA = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  localparam logic [BYTE_W-1:0] CMD_SET_CONTRAST = 8'h81;
  localparam logic [BYTE_W-1:0] CMD_ALL_ON_OFF   = 8'hA4;
  localparam logic [BYTE_W-1:0] CMD_ALL_ON_ON    = 8'hA5;
  localparam logic [BYTE_W-1:0] CMD_NORMAL       = 8'hA6;
  localparam logic [BYTE_W-1:0] CMD_INVERSE      = 8'hA7;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF  = 8'hAE;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON   = 8'hAF;

  localparam int unsigned DIM_NUM = 48;

  typedef struct packed {
    logic accept;
    logic load_out;
    logic clear_wr;
  } moc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_hold;
  } moc_sts_t;

endpackage

`default_nettype wire

// ===== design/moc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module moc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/moc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module moc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           opcode_i,
  output logic                      in_stall_o,
  input  wire moc_pkg::moc_sts_t    sts_i,
  output moc_pkg::moc_cmd_t         cmd_o
);

  import moc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = accept;
    cmd_o.load_out = 1'b0;
    cmd_o.clear_wr = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (opcode_e'(opcode_i) == OP_READ)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts_i.out_hold) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/moc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module moc_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire moc_pkg::moc_cmd_t    cmd_i,
  output moc_pkg::moc_sts_t         sts_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic                 transfer_start_i,
  input  wire logic [6:0]           column_i,
  input  wire logic [5:0]           row_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                pixel_level_o
);

  import moc_pkg::*;

  localparam int unsigned CMP_W  = 10;
  localparam int unsigned PROD_W = 16;

  opcode_e           op;
  logic              is_cmd, is_data, is_read;

  logic [BYTE_W-1:0] contrast_q, contrast_d;
  logic              pending_q, pending_d;
  logic              all_on_q, all_on_d;
  logic              inverse_q, inverse_d;
  logic              enabled_q, enabled_d;

  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [ADDR_W-1:0] wbase;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              oor;
  logic              oor_q;
  logic [2:0]        bitsel_q;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dim_sum;
  logic [BYTE_W-1:0] dim;
  logic [BYTE_W-1:0] fg, bg, fg_s, bg_s, level;
  logic              pix;

  logic              out_valid_q;
  logic [BYTE_W-1:0] level_q;

  assign op      = opcode_e'(opcode_i);
  assign is_cmd  = cmd_i.accept && (op == OP_CMD);
  assign is_data = cmd_i.accept && (op == OP_DATA);
  assign is_read = cmd_i.accept && (op == OP_READ);

  // mode register updates
  always_comb begin
    contrast_d = contrast_q;
    pending_d  = pending_q;
    all_on_d   = all_on_q;
    inverse_d  = inverse_q;
    enabled_d  = enabled_q;
    if (is_cmd) begin
      if (pending_q) begin
        contrast_d = byte_value_i;
        pending_d  = 1'b0;
      end else begin
        unique case (byte_value_i)
          CMD_SET_CONTRAST: pending_d = 1'b1;
          CMD_ALL_ON_OFF:   all_on_d  = 1'b0;
          CMD_ALL_ON_ON:    all_on_d  = 1'b1;
          CMD_NORMAL:       inverse_d = 1'b0;
          CMD_INVERSE:      inverse_d = 1'b1;
          CMD_DISPLAY_OFF:  enabled_d = 1'b0;
          CMD_DISPLAY_ON:   enabled_d = 1'b1;
          default: ;
        endcase
      end
    end
  end

  // write pointer, wraps at end of frame memory
  assign wbase  = transfer_start_i ? '0 : wptr_q;
  assign wptr_d = (wbase == ADDR_W'(MEM_SIZE - 1)) ? '0 : wbase + ADDR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= CONTRAST_RESET;
      pending_q  <= 1'b0;
      all_on_q   <= 1'b0;
      inverse_q  <= 1'b0;
      enabled_q  <= 1'b0;
      wptr_q     <= '0;
      clr_cnt_q  <= '0;
    end else begin
      contrast_q <= contrast_d;
      pending_q  <= pending_d;
      all_on_q   <= all_on_d;
      inverse_q  <= inverse_d;
      enabled_q  <= enabled_d;
      if (is_data) begin
        wptr_q <= wptr_d;
      end
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == ADDR_W'(MEM_SIZE - 1));

  // frame memory port steering
  assign ram_we    = cmd_i.clear_wr || is_data;
  assign ram_waddr = cmd_i.clear_wr ? clr_cnt_q : wbase;
  assign ram_wdata = cmd_i.clear_wr ? '0 : byte_value_i;
  assign ram_re    = is_read;
  assign ram_raddr = ADDR_W'(column_i) + ADDR_W'(PANEL_WIDTH) * ADDR_W'(row_i >> 3);

  assign oor = (CMP_W'(column_i) >= CMP_W'(PANEL_WIDTH)) ||
               (CMP_W'(row_i) >= CMP_W'(PANEL_HEIGHT));

  moc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_SIZE)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      oor_q    <= oor;
      bitsel_q <= row_i[2:0];
    end
  end

  // 48*c/255 by reciprocal: (x + (x >> 8) + 1) >> 8
  assign prod    = PROD_W'(contrast_q) * PROD_W'(DIM_NUM);
  assign dim_sum = prod + (prod >> 8) + PROD_W'(1);
  assign dim     = dim_sum[15:8];

  assign pix   = ram_rdata[bitsel_q];
  assign fg    = enabled_q ? contrast_q : '0;
  assign bg    = (!enabled_q || all_on_q) ? fg : dim;
  assign fg_s  = inverse_q ? bg : fg;
  assign bg_s  = inverse_q ? fg : bg;
  assign level = oor_q ? '0 : (pix ? fg_s : bg_s);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      level_q <= level;
    end
  end

  assign sts_o.out_hold = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign pixel_level_o  = level_q;

endmodule

`default_nettype wire

// ===== design/mono_oled_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake              payload
// in       request    in_valid_i/in_stall_o  opcode_i byte_value_i transfer_start_i column_i row_i
// out      result     out_valid_o/out_stall_i pixel_level_o
//
// command and data bytes are accepted without stalling the input; a pixel read
// stalls it in a read state, set by the registered read port of the frame memory
// a read waits further while the output register holds an untaken result
// after reset a clearing pass writes zero to all 1024 frame bytes, one per
// cycle; in_stall_o stays high for the whole pass

module mono_oled_controller (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       transfer_start_i,
  input  wire logic [6:0] column_i,
  input  wire logic [5:0] row_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      pixel_level_o
);

  import moc_pkg::*;

  moc_cmd_t cmd;
  moc_sts_t sts;

  moc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  moc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .byte_value_i     (byte_value_i),
    .transfer_start_i (transfer_start_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_level_o    (pixel_level_o)
  );

  // no request taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_wr |-> in_stall_o)
    else $error("request accepted while frame memory clears");

  // an accepted read blocks the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && (opcode_i == OP_READ)) |=> in_stall_o)
    else $error("input open while a read is in flight");

  // a result appears only after a load from the read path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result without a load");

  // loading never overwrites a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.load_out)
    else $error("held result overwritten");

endmodule

`default_nettype wire

// ===== tb/oled_level_checker.sv =====
`timescale 1ns / 1ps

module oled_level_checker
  import moc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              transfer_start_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  logic [BYTE_W-1:0] pixel_level_i,
  output int unsigned       mismatches_o,
  output int unsigned       levels_due_o,
  output int unsigned       requests_o,
  output int unsigned       compared_o,
  output int unsigned       wraps_o
);

  localparam int unsigned DIM_DEN = 255;

  logic [BYTE_W-1:0] frame [MEM_SIZE];
  int unsigned       wr_ptr;
  int unsigned       slot;
  logic [BYTE_W-1:0] contrast;
  logic              contrast_due;
  logic              all_lit;
  logic              inverted;
  logic              panel_on;
  logic [BYTE_W-1:0] levels_due [$];
  logic [BYTE_W-1:0] want;

  function automatic logic [BYTE_W-1:0] gray_level(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
    int unsigned       idx;
    logic              lit;
    logic [BYTE_W-1:0] fg;
    logic [BYTE_W-1:0] bg;
    logic [BYTE_W-1:0] swap;
    if (col >= PANEL_WIDTH || row >= PANEL_HEIGHT) return '0;
    idx = col + PANEL_WIDTH * (row >> 3);
    if (idx >= MEM_SIZE) return '0;
    lit = frame[idx][row[2:0]];
    fg = panel_on ? contrast : '0;
    bg = (!panel_on || all_lit) ? fg : 8'((DIM_NUM * contrast) / DIM_DEN);
    if (inverted) begin
      swap = fg;
      fg = bg;
      bg = swap;
    end
    return lit ? fg : bg;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame[i]) frame[i] = '0;
      wr_ptr = 0;
      contrast = CONTRAST_RESET;
      contrast_due = 1'b0;
      all_lit = 1'b0;
      inverted = 1'b0;
      panel_on = 1'b0;
      levels_due.delete();
      mismatches_o = 0;
      levels_due_o = 0;
      requests_o = 0;
      compared_o = 0;
      wraps_o = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (levels_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: pixel level expected none actual %0d", $time, pixel_level_i);
        end else begin
          want = levels_due.pop_front();
          compared_o++;
          if (pixel_level_i !== want) begin
            mismatches_o++;
            $display("%0t: pixel level expected %0d actual %0d", $time, want, pixel_level_i);
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        requests_o++;
        case (opcode_i)
          OP_CMD: begin
            if (contrast_due) begin
              contrast = byte_value_i;
              contrast_due = 1'b0;
            end else begin
              case (byte_value_i)
                CMD_SET_CONTRAST: contrast_due = 1'b1;
                CMD_ALL_ON_OFF:   all_lit = 1'b0;
                CMD_ALL_ON_ON:    all_lit = 1'b1;
                CMD_NORMAL:       inverted = 1'b0;
                CMD_INVERSE:      inverted = 1'b1;
                CMD_DISPLAY_OFF:  panel_on = 1'b0;
                CMD_DISPLAY_ON:   panel_on = 1'b1;
                default: ;
              endcase
            end
          end
          OP_DATA: begin
            slot = transfer_start_i ? 0 : wr_ptr;
            if (slot >= MEM_SIZE) slot = 0;
            frame[slot] = byte_value_i;
            slot++;
            if (slot >= MEM_SIZE) begin
              slot = 0;
              wraps_o++;
            end
            wr_ptr = slot;
          end
          OP_READ: levels_due.push_back(gray_level(column_i, row_i));
          default: ;
        endcase
      end
      levels_due_o = levels_due.size();
    end
  end

endmodule

// ===== tb/tb_mono_oled_controller.sv =====
`timescale 1ns / 1ps

module tb_mono_oled_controller;
  import moc_pkg::*;

  localparam int unsigned ITEM_BUDGET = 1750;
  localparam int unsigned FILL_LEN    = MEM_SIZE + 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN       = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [BYTE_W-1:0] byte_value_i;
  logic              transfer_start_i;
  logic [COL_W-1:0]  column_i;
  logic [ROW_W-1:0]  row_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] pixel_level_o;

  int unsigned mismatches;
  int unsigned levels_due;
  int unsigned requests;
  int unsigned compared;
  int unsigned wraps;
  int unsigned sent   = 0;
  int unsigned cycles = 0;
  bit          calm   = 1'b0;

  mono_oled_controller dut (.*);

  oled_level_checker u_level_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .req_stall_i     (in_stall_o),
    .opcode_i        (opcode_i),
    .byte_value_i    (byte_value_i),
    .transfer_start_i(transfer_start_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .res_valid_i     (out_valid_o),
    .res_stall_i     (out_stall_i),
    .pixel_level_i   (pixel_level_o),
    .mismatches_o    (mismatches),
    .levels_due_o    (levels_due),
    .requests_o      (requests),
    .compared_o      (compared),
    .wraps_o         (wraps)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("mono_oled_controller verification failed");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send(input opcode_e op, input logic [BYTE_W-1:0] b, input logic st,
                      input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    int unsigned gap;
    gap = idle_draw();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    byte_value_i     <= b;
    transfer_start_i <= st;
    column_i         <= c;
    row_i            <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent++;
  endtask

  task automatic cmd(input logic [BYTE_W-1:0] b);
    send(OP_CMD, b, 1'($urandom_range(0, 1)), 7'($urandom), 6'($urandom));
  endtask

  task automatic put(input logic [BYTE_W-1:0] b, input logic st);
    send(OP_DATA, b, st, 7'($urandom), 6'($urandom));
  endtask

  task automatic peek(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    send(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), c, r);
  endtask

  // result side back-pressure
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = idle_draw();
      do @(negedge clk_i); while (out_valid_o !== 1'b1);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    int unsigned       seg;
    int unsigned       len;
    int unsigned       pick;
    int unsigned       k;
    logic [BYTE_W-1:0] level;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_CMD;
    byte_value_i     = '0;
    transfer_start_i = 1'b0;
    column_i         = '0;
    row_i            = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    peek(7'd0, 6'd0);
    cmd(CMD_DISPLAY_ON);
    peek(7'd127, 6'd63);
    put(8'hFF, 1'b1);
    put(8'h80, 1'b0);
    peek(7'd0, 6'd0);
    peek(7'd1, 6'd7);
    peek(7'd1, 6'd6);
    cmd(CMD_INVERSE);
    peek(7'd0, 6'd0);
    cmd(CMD_ALL_ON_ON);
    peek(7'd1, 6'd6);
    cmd(CMD_NORMAL);
    cmd(CMD_ALL_ON_OFF);
    // contrast value held over a later transfer
    cmd(CMD_SET_CONTRAST);
    put(8'h00, 1'b1);
    cmd(8'h00);
    peek(7'd0, 6'd0);
    cmd(CMD_SET_CONTRAST);
    cmd(CMD_SET_CONTRAST);
    cmd(CMD_SET_CONTRAST);
    cmd(8'hFF);
    cmd(8'h00);
    send(OP_NONE, 8'hFF, 1'b1, 7'h7F, 6'h3F);
    peek(7'd1, 6'd7);
    cmd(CMD_DISPLAY_OFF);
    peek(7'd1, 6'd7);

    // whole frame and past the pointer wrap
    for (k = 0; k < FILL_LEN; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      put(8'($urandom), k == 0);
    end
    cmd(CMD_DISPLAY_ON);

    while (sent < ITEM_BUDGET) begin
      calm = ($urandom_range(0, 4) == 0);
      seg = $urandom_range(0, 9);
      case (seg)
        0, 1, 2: begin
          len = $urandom_range(1, 24);
          for (k = 0; k < len; k++)
            put(8'($urandom), (k == 0) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 19) == 0));
        end
        3, 4, 5: begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len; k++) peek(7'($urandom), 6'($urandom));
        end
        6, 7: begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2: begin
              cmd(CMD_SET_CONTRAST);
              if ($urandom_range(0, 2) == 0) peek(7'($urandom), 6'($urandom));
              if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              else level = 8'($urandom);
              cmd(level);
            end
            3: cmd(CMD_ALL_ON_OFF);
            4: cmd(CMD_ALL_ON_ON);
            5: cmd(CMD_NORMAL);
            6: cmd(CMD_INVERSE);
            7: cmd(CMD_DISPLAY_OFF);
            default: cmd(CMD_DISPLAY_ON);
          endcase
        end
        8: begin
          if ($urandom_range(0, 1)) cmd(8'($urandom));
          else send(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)), 7'($urandom),
                    6'($urandom));
        end
        default: begin
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++) begin
            put(8'($urandom), 1'b0);
            peek(7'($urandom), 6'($urandom));
          end
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (levels_due != 0) @(negedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d requests of all opcodes driven, %0d pixel levels compared", requests,
             compared);
    $display("write pointer wrapped %0d time(s), mode and contrast changes mixed in", wraps);
    if (mismatches == 0) $display("mono_oled_controller verification clean");
    else $display("mono_oled_controller verification failed");
    $finish;
  end

endmodule
